@@ sv/gmb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package gmb_pkg;

  localparam int MESH_VERTS    = 16384;
  localparam int MESHLET_VERTS = 64;
  localparam int MESHLET_TRIS  = 126;

  localparam int IDX_W   = 14;
  localparam int SLOT_W  = 6;
  localparam int CNT_W   = 7;
  localparam int NUM_W   = 16;
  localparam int CFG_W   = 7;

  localparam logic CFG_VERTEX_LIMIT   = 1'b0;
  localparam logic CFG_TRIANGLE_LIMIT = 1'b1;

  typedef struct packed {
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [IDX_W-1:0] c;
    logic             mesh_end;
    logic             eq_ba;
    logic             eq_ca;
    logic             eq_cb;
  } item_t;

  typedef struct packed {
    logic [CNT_W-1:0] vlim;
    logic [CNT_W-1:0] tlim;
  } limits_t;

  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
  } entry_t;

endpackage
`default_nettype wire

@@ sv/gmb_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module gmb_front
  import gmb_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [IDX_W-1:0] vertex_a,
  input  wire logic [IDX_W-1:0] vertex_b,
  input  wire logic [IDX_W-1:0] vertex_c,
  input  wire logic             mesh_end,
  output logic                  q_valid,
  output item_t                 q_item,
  input  wire logic             q_pop
);

  item_t      fifo [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  item_t      incoming;
  logic       push;

  always_comb begin
    incoming.a        = vertex_a;
    incoming.b        = vertex_b;
    incoming.c        = vertex_c;
    incoming.mesh_end = mesh_end;
    incoming.eq_ba    = (vertex_b == vertex_a);
    incoming.eq_ca    = (vertex_c == vertex_a);
    incoming.eq_cb    = (vertex_c == vertex_b);
  end

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_item   = fifo[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (q_pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule
`default_nettype wire

@@ sv/gmb_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module gmb_back
  import gmb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  input  wire item_t             q_item,
  output logic                   q_pop,
  input  wire limits_t           lim,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [NUM_W-1:0]       meshlet_number,
  output logic                   starts_meshlet,
  output logic [SLOT_W-1:0]      slot_a,
  output logic [SLOT_W-1:0]      slot_b,
  output logic [SLOT_W-1:0]      slot_c,
  output logic                   added_a,
  output logic                   added_b,
  output logic                   added_c,
  output logic [CNT_W-1:0]       meshlet_vertices_used,
  output logic [CNT_W-1:0]       meshlet_triangles_used,
  output logic                   mesh_done
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RB    = 4'd2;
  localparam logic [3:0] S_RC    = 4'd3;
  localparam logic [3:0] S_RD    = 4'd4;
  localparam logic [3:0] S_WALK  = 4'd5;
  localparam logic [3:0] S_TA    = 4'd6;
  localparam logic [3:0] S_TB    = 4'd7;
  localparam logic [3:0] S_TC    = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MESH_VERTS - 1);
  localparam logic [CNT_W-1:0] MAX_VERTS = CNT_W'(MESHLET_VERTS);

  logic [3:0]       state;
  logic [IDX_W-1:0] clr_addr;

  entry_t           slot_map [MESH_VERTS];
  logic [IDX_W-1:0] map_addr;
  logic             map_we;
  entry_t           map_wd;
  entry_t           map_rd;

  logic [IDX_W-1:0] list_mem [MESHLET_VERTS];
  logic             list_we;
  logic [SLOT_W-1:0] list_wa;
  logic [SLOT_W-1:0] list_ra;
  logic [IDX_W-1:0] list_rd;

  entry_t           ent_a;
  entry_t           ent_b;
  entry_t           ent_c;
  logic             cleared;
  logic [CNT_W-1:0] vcnt;
  logic [CNT_W-1:0] tcnt;
  logic [NUM_W-1:0] mcount;
  logic [CNT_W-1:0] walk_k;
  logic             walk_pend;
  logic             walk_to_idle;
  logic [SLOT_W-1:0] sl [3];
  logic [2:0]       ad;
  logic [2:0]       pv;
  logic [1:0]       corner;

  logic [IDX_W-1:0] cur_v;
  logic             cur_valid;
  logic [SLOT_W-1:0] cur_slot;
  logic             cur_add;
  logic [1:0]       fresh;
  logic [CNT_W:0]   vsum;
  logic             do_close;
  logic             walk_issue;
  logic             out_free;

  assign out_free = !out_valid || !out_stall;
  assign q_pop    = (state == S_EMIT) && out_free;
  assign corner   = state[1:0] - S_TA[1:0];

  // current corner, seen after earlier corners of the same triangle
  always_comb begin
    cur_v     = q_item.a;
    cur_valid = !cleared && ent_a.valid;
    cur_slot  = ent_a.slot;
    case (state)
      S_TB: begin
        cur_v = q_item.b;
        if (q_item.eq_ba) begin
          cur_valid = pv[0];
          cur_slot  = sl[0];
        end else begin
          cur_valid = !cleared && ent_b.valid;
          cur_slot  = ent_b.slot;
        end
      end
      S_TC: begin
        cur_v = q_item.c;
        if (q_item.eq_cb) begin
          cur_valid = pv[1];
          cur_slot  = sl[1];
        end else if (q_item.eq_ca) begin
          cur_valid = pv[0];
          cur_slot  = sl[0];
        end else begin
          cur_valid = !cleared && ent_c.valid;
          cur_slot  = ent_c.slot;
        end
      end
      default: ;
    endcase
    cur_add = !cur_valid && (vcnt < MAX_VERTS);
  end

  always_comb begin
    fresh    = {1'b0, !ent_a.valid} + {1'b0, !ent_b.valid} + {1'b0, !map_rd.valid};
    vsum     = {1'b0, vcnt} + {{(CNT_W-1){1'b0}}, fresh};
    do_close = (tcnt != '0) &&
               ((vsum > {1'b0, lim.vlim}) || ({1'b0, tcnt} + 1'b1 > {1'b0, lim.tlim}));
  end

  assign walk_issue = (walk_k < vcnt);

  always_comb begin
    map_addr = q_item.a;
    map_we   = 1'b0;
    map_wd   = '0;
    list_we  = 1'b0;
    list_wa  = vcnt[SLOT_W-1:0];
    list_ra  = walk_k[SLOT_W-1:0];
    case (state)
      S_CLEAR: begin
        map_addr = clr_addr;
        map_we   = 1'b1;
      end
      S_RB: map_addr = q_item.b;
      S_RC: map_addr = q_item.c;
      S_WALK: begin
        map_addr = list_rd;
        map_we   = walk_pend;
      end
      S_TA, S_TB, S_TC: begin
        map_addr    = cur_v;
        map_we      = cur_add;
        map_wd.valid = 1'b1;
        map_wd.slot  = vcnt[SLOT_W-1:0];
        list_we     = cur_add;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (map_we) slot_map[map_addr] <= map_wd;
    map_rd <= slot_map[map_addr];
  end

  always_ff @(posedge clk) begin
    if (list_we) list_mem[list_wa] <= cur_v;
    list_rd <= list_mem[list_ra];
  end

  // map reads, per-corner results and output registers
  always_ff @(posedge clk) begin
    case (state)
      S_RB: ent_a <= map_rd;
      S_RC: ent_b <= map_rd;
      S_RD: ent_c <= map_rd;
      S_TA, S_TB, S_TC: begin
        sl[corner] <= cur_add ? vcnt[SLOT_W-1:0] : cur_slot;
        ad[corner] <= cur_add;
        pv[corner] <= cur_valid || cur_add;
      end
      default: ;
    endcase
    if (state == S_EMIT && out_free) begin
      meshlet_number         <= mcount;
      starts_meshlet         <= (tcnt == '0);
      slot_a                 <= sl[0];
      slot_b                 <= sl[1];
      slot_c                 <= sl[2];
      added_a                <= ad[0];
      added_b                <= ad[1];
      added_c                <= ad[2];
      meshlet_vertices_used  <= vcnt;
      meshlet_triangles_used <= tcnt + 1'b1;
      mesh_done              <= q_item.mesh_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      cleared      <= 1'b0;
      vcnt         <= '0;
      tcnt         <= '0;
      mcount       <= '0;
      walk_k       <= '0;
      walk_pend    <= 1'b0;
      walk_to_idle <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_IDX) state <= S_IDLE;
        end
        S_IDLE: begin
          cleared <= 1'b0;
          if (q_valid) state <= S_RB;
        end
        S_RB: state <= S_RC;
        S_RC: state <= S_RD;
        S_RD: begin
          if (do_close) begin
            cleared      <= 1'b1;
            mcount       <= mcount + 1'b1;
            walk_k       <= '0;
            walk_pend    <= 1'b0;
            walk_to_idle <= 1'b0;
            state        <= S_WALK;
          end else begin
            state <= S_TA;
          end
        end
        S_WALK: begin
          // read list entry, drop its map entry on the next cycle
          walk_pend <= walk_issue;
          if (walk_issue) begin
            walk_k <= walk_k + 1'b1;
          end else if (!walk_pend) begin
            vcnt  <= '0;
            tcnt  <= '0;
            state <= walk_to_idle ? S_IDLE : S_TA;
          end
        end
        S_TA, S_TB, S_TC: begin
          if (cur_add) vcnt <= vcnt + 1'b1;
          state <= state + 1'b1;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            tcnt      <= tcnt + 1'b1;
            if (q_item.mesh_end) begin
              mcount       <= '0;
              walk_k       <= '0;
              walk_pend    <= 1'b0;
              walk_to_idle <= 1'b1;
              state        <= S_WALK;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ sv/greedy_meshlet_builder.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel   Handshake              Payload
// input     in_valid / in_stall    vertex_a, vertex_b, vertex_c, mesh_end
// output    out_valid / out_stall  meshlet_number .. mesh_done
// config    cfg_write              cfg_index, cfg_data
//
// A triangle uses the single slot map port in order: three reads, a decide
// step, three corner steps that write new vertices and an emit. Closing a
// meshlet adds a release walk over its vertices; a mesh end runs it after
// the emit. After reset a clearing pass over all 16384 slot map entries runs
// before the first transfer is processed; up to two triangles queue meanwhile.
// A stalled result holds the back end at emit while the queue fills up.
module greedy_meshlet_builder
  import gmb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [IDX_W-1:0]  vertex_a,
  input  wire logic [IDX_W-1:0]  vertex_b,
  input  wire logic [IDX_W-1:0]  vertex_c,
  input  wire logic              mesh_end,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [NUM_W-1:0]       meshlet_number,
  output logic                   starts_meshlet,
  output logic [SLOT_W-1:0]      slot_a,
  output logic [SLOT_W-1:0]      slot_b,
  output logic [SLOT_W-1:0]      slot_c,
  output logic                   added_a,
  output logic                   added_b,
  output logic                   added_c,
  output logic [CNT_W-1:0]       meshlet_vertices_used,
  output logic [CNT_W-1:0]       meshlet_triangles_used,
  output logic                   mesh_done,
  input  wire logic              cfg_write,
  input  wire logic              cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  logic [CFG_W-1:0] vertex_limit;
  logic [CFG_W-1:0] triangle_limit;
  limits_t          lim;
  logic             q_valid;
  item_t            q_item;
  logic             q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_limit   <= CFG_W'(MESHLET_VERTS);
      triangle_limit <= CFG_W'(MESHLET_TRIS);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_VERTEX_LIMIT:   vertex_limit   <= cfg_data;
        CFG_TRIANGLE_LIMIT: triangle_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp to 3..64 vertices and 1..126 triangles, so a fresh meshlet always takes a triangle
  always_comb begin
    if (vertex_limit < CFG_W'(3))                  lim.vlim = CFG_W'(3);
    else if (vertex_limit > CFG_W'(MESHLET_VERTS)) lim.vlim = CFG_W'(MESHLET_VERTS);
    else                                           lim.vlim = vertex_limit;
    if (triangle_limit < CFG_W'(1))                  lim.tlim = CFG_W'(1);
    else if (triangle_limit > CFG_W'(MESHLET_TRIS))  lim.tlim = CFG_W'(MESHLET_TRIS);
    else                                             lim.tlim = triangle_limit;
  end

  gmb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .vertex_a (vertex_a),
    .vertex_b (vertex_b),
    .vertex_c (vertex_c),
    .mesh_end (mesh_end),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  gmb_back u_back (
    .clk                    (clk),
    .rst                    (rst),
    .q_valid                (q_valid),
    .q_item                 (q_item),
    .q_pop                  (q_pop),
    .lim                    (lim),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .meshlet_number         (meshlet_number),
    .starts_meshlet         (starts_meshlet),
    .slot_a                 (slot_a),
    .slot_b                 (slot_b),
    .slot_c                 (slot_c),
    .added_a                (added_a),
    .added_b                (added_b),
    .added_c                (added_c),
    .meshlet_vertices_used  (meshlet_vertices_used),
    .meshlet_triangles_used (meshlet_triangles_used),
    .mesh_done              (mesh_done)
  );

endmodule
`default_nettype wire
